// ===== hdl/fatlb_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fatlb_pkg
// Shared operation codes and controller command types for the translation
// buffer.
// ============================================================================
package fatlb_pkg;

    localparam int OP_WIDTH = 2;

    typedef logic [OP_WIDTH-1:0] op_t;

    localparam op_t OP_LOOKUP = 2'd0;
    localparam op_t OP_INSERT = 2'd1;
    localparam op_t OP_REMOVE = 2'd2;
    localparam op_t OP_FLUSH  = 2'd3;

    // Commands from the controller to the datapath, one step per field.
    typedef struct packed {
        logic capture;   // register the accepted request
        logic match;     // register the match vector
        logic act;       // resolve the match and update the entries
        logic load_out;  // load the response register
    } cmd_t;

endpackage

// ===== hdl/fatlb_req_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fatlb_req_if
// Request channel: operation, page and frame with a valid/ready handshake.
// ============================================================================
interface fatlb_req_if #(
    parameter int PAGE_WIDTH  = 20,
    parameter int FRAME_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic [fatlb_pkg::OP_WIDTH-1:0] op;
    logic [PAGE_WIDTH-1:0]        page_number;
    logic [FRAME_WIDTH-1:0]       frame_number;

    modport source (output valid, op, page_number, frame_number, input ready);
    modport sink   (input valid, op, page_number, frame_number, output ready);
endinterface

// ===== hdl/fatlb_rsp_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fatlb_rsp_if
// Response channel: hit flag and frame with a valid/ready handshake.
// ============================================================================
interface fatlb_rsp_if #(
    parameter int FRAME_WIDTH = 16
);
    logic                   valid;
    logic                   ready;
    logic                   hit;
    logic [FRAME_WIDTH-1:0] frame_out;

    modport source (output valid, hit, frame_out, input ready);
    modport sink   (input valid, hit, frame_out, output ready);
endinterface

// ===== hdl/fatlb_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fatlb_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module fatlb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/fatlb_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fatlb_ctrl
// Sequencer that steps one transaction through match, update and response,
// and owns both channel handshakes.
// ============================================================================
module fatlb_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output fatlb_pkg::cmd_t cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MATCH = 2'd1;
    localparam logic [1:0] ST_ACT   = 2'd2;
    localparam logic [1:0] ST_RESP  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next       = state_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        cmd              = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                cmd.match  = 1'b1;
                state_next = ST_ACT;
            end
            ST_ACT:
            begin
                cmd.act    = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                // The response register may still hold the previous result.
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/fatlb_dp.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fatlb_dp
// Entry storage, parallel page match, FIFO replacement pointer and the
// response register.
// ============================================================================
module fatlb_dp #(
    parameter int ENTRIES     = 16,
    parameter int PAGE_WIDTH  = 20,
    parameter int FRAME_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  fatlb_pkg::cmd_t                    cmd,
    input  logic [fatlb_pkg::OP_WIDTH-1:0]     op,
    input  logic [PAGE_WIDTH-1:0]              page_number,
    input  logic [FRAME_WIDTH-1:0]             frame_number,
    output logic                               hit,
    output logic [FRAME_WIDTH-1:0]             frame_out
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    fatlb_pkg::op_t         op_reg;
    logic [PAGE_WIDTH-1:0]  page_reg;
    logic [FRAME_WIDTH-1:0] frame_reg;

    logic [PAGE_WIDTH-1:0]  entry_page_reg [ENTRIES];
    logic [ENTRIES-1:0]     valid_reg;
    logic [ENTRIES-1:0]     valid_next;
    logic [IDX_W-1:0]       ptr_reg;
    logic [IDX_W-1:0]       ptr_next;
    logic [ENTRIES-1:0]     match_reg;
    logic [ENTRIES-1:0]     match_vec;

    logic                   found;
    logic [IDX_W-1:0]       match_idx;
    logic                   lookup_hit_reg;
    logic                   out_hit_reg;
    logic [FRAME_WIDTH-1:0] out_frame_reg;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic                   ram_re;
    logic [FRAME_WIDTH-1:0] ram_rdata;
    logic                   alloc;

    // Compare the captured page against every entry at once.
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_vec[i] = valid_reg[i] && (entry_page_reg[i] == page_reg);
        end
    end

    // The lowest matching index wins.
    always_comb
    begin
        found     = 1'b0;
        match_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                found     = 1'b1;
                match_idx = IDX_W'(i);
            end
        end
    end

    assign alloc     = cmd.act && (op_reg == fatlb_pkg::OP_INSERT) && !found;
    assign ram_we    = cmd.act && (op_reg == fatlb_pkg::OP_INSERT);
    assign ram_waddr = found ? match_idx : ptr_reg;
    assign ram_re    = cmd.act && (op_reg == fatlb_pkg::OP_LOOKUP) && found;

    always_comb
    begin
        valid_next = valid_reg;
        ptr_next   = ptr_reg;
        if (cmd.act)
        begin
            unique case (op_reg)
                fatlb_pkg::OP_LOOKUP:
                begin
                    valid_next = valid_reg;
                end
                fatlb_pkg::OP_INSERT:
                begin
                    if (!found)
                    begin
                        valid_next[ptr_reg] = 1'b1;
                        ptr_next = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;
                    end
                end
                fatlb_pkg::OP_REMOVE:
                begin
                    if (found)
                    begin
                        valid_next[match_idx] = 1'b0;
                    end
                end
                fatlb_pkg::OP_FLUSH:
                begin
                    valid_next = '0;
                    ptr_next   = '0;
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op;
            page_reg  <= page_number;
            frame_reg <= frame_number;
        end
        if (cmd.match)
        begin
            match_reg <= match_vec;
        end
        if (cmd.act)
        begin
            lookup_hit_reg <= (op_reg == fatlb_pkg::OP_LOOKUP) && found;
        end
        if (alloc)
        begin
            entry_page_reg[ptr_reg] <= page_reg;
        end
        if (cmd.load_out)
        begin
            out_hit_reg   <= lookup_hit_reg;
            out_frame_reg <= lookup_hit_reg ? ram_rdata : '0;
        end
    end

    fatlb_ram #(
        .WIDTH (FRAME_WIDTH),
        .DEPTH (ENTRIES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (frame_reg),
        .re    (ram_re),
        .raddr (match_idx),
        .rdata (ram_rdata)
    );

    assign hit       = out_hit_reg;
    assign frame_out = out_frame_reg;

endmodule

// ===== hdl/fifo_fully_associative_tlb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fifo_fully_associative_tlb
// Fully associative translation buffer with FIFO replacement.
// ============================================================================
// Usage:
// Requests arrive on the req channel (op, page_number, frame_number) and each
// request produces exactly one response transaction on the rsp channel (hit,
// frame_out). Operations are lookup, insert/update, remove and flush.
// Lookup returns the frame of the lowest-index valid matching entry; a miss,
// and every non-lookup operation, answers with hit 0 and frame 0.
// Insert updates a matching entry in place, or else writes the slot under
// the circular replacement pointer and advances it, whether or not other
// slots are free.
// One transaction at a time is processed: accept, match, update, respond.
// The response becomes valid after the match, update and response-load steps,
// and the sequencer passes through its idle step before it takes a new request.
// The response register decouples the channels: a new request is accepted
// while the previous response still waits. If the receiver still stalls when
// the next transaction reaches its response step, that transaction holds
// there and req.ready stays low.
// Reset clears all valid bits and the replacement pointer; no sweep is needed.
// ============================================================================
module fifo_fully_associative_tlb #(
    parameter int ENTRIES     = 16,
    parameter int PAGE_WIDTH  = 20,
    parameter int FRAME_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    fatlb_req_if.sink   req,
    fatlb_rsp_if.source rsp
);

    fatlb_pkg::cmd_t cmd;

    // The controller sequences the steps and owns the handshakes.
    fatlb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // The datapath holds entries, the replacement pointer and the result.
    fatlb_dp #(
        .ENTRIES     (ENTRIES),
        .PAGE_WIDTH  (PAGE_WIDTH),
        .FRAME_WIDTH (FRAME_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .op           (req.op),
        .page_number  (req.page_number),
        .frame_number (req.frame_number),
        .hit          (rsp.hit),
        .frame_out    (rsp.frame_out)
    );

endmodule

// ===== tb/sv/tlb_translation_monitor.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tlb_translation_monitor
// Watches the request and response channels of the translation buffer,
// keeps a shadow copy of its entries, predicts the answer to every accepted
// request and compares it with the response that comes back.
// ============================================================================
module tlb_translation_monitor #(
    parameter int ENTRIES     = 16,
    parameter int PAGE_WIDTH  = 20,
    parameter int FRAME_WIDTH = 16
) (
    input  logic  clk,
    input  logic  rst_n,
    fatlb_req_if  req,
    fatlb_rsp_if  rsp,
    output int    mismatch_count,
    output int    translations_awaited
);

    typedef struct packed {
        logic                   hit;
        logic [FRAME_WIDTH-1:0] frame;
    } answer_t;

    logic [PAGE_WIDTH-1:0]  shadow_page  [ENTRIES];
    logic [FRAME_WIDTH-1:0] shadow_frame [ENTRIES];
    logic [ENTRIES-1:0]     shadow_valid;
    int                     shadow_ptr;
    answer_t                awaited_answers [$];
    int                     errs = 0;

    // Applies one request to the shadow entries and returns its answer.
    // The lowest-index valid match wins for lookup, update and remove.
    function automatic answer_t predict_translation(
        fatlb_pkg::op_t         op,
        logic [PAGE_WIDTH-1:0]  page,
        logic [FRAME_WIDTH-1:0] frame
    );
        answer_t answer;
        int      slot;
        answer = '0;
        slot   = -1;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (shadow_valid[i] && shadow_page[i] == page)
                slot = i;
        end
        case (op)
            fatlb_pkg::OP_LOOKUP:
            begin
                if (slot >= 0)
                begin
                    answer.hit   = 1'b1;
                    answer.frame = shadow_frame[slot];
                end
            end
            fatlb_pkg::OP_INSERT:
            begin
                if (slot >= 0)
                    shadow_frame[slot] = frame;
                else
                begin
                    shadow_page[shadow_ptr]  = page;
                    shadow_frame[shadow_ptr] = frame;
                    shadow_valid[shadow_ptr] = 1'b1;
                    shadow_ptr = (shadow_ptr + 1) % ENTRIES;
                end
            end
            fatlb_pkg::OP_REMOVE:
            begin
                if (slot >= 0)
                    shadow_valid[slot] = 1'b0;
            end
            default:
            begin
                shadow_valid = '0;
                shadow_ptr   = 0;
            end
        endcase
        return answer;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        answer_t oldest;
        if (!rst_n)
        begin
            shadow_valid = '0;
            shadow_ptr   = 0;
            awaited_answers.delete();
            mismatch_count       <= errs;
            translations_awaited <= 0;
        end
        else
        begin
            // Responses are compared before the request of this edge is
            // queued, so a response can never match its own request.
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_answers.size() == 0)
                begin
                    errs++;
                    $display("%0t: response with none outstanding, %s hit %0b frame %h",
                             $time, "expected none, got", rsp.hit, rsp.frame_out);
                end
                else
                begin
                    oldest = awaited_answers.pop_front();
                    if (rsp.hit !== oldest.hit)
                    begin
                        errs++;
                        $display("%0t: hit mismatch, expected %0b, got %0b",
                                 $time, oldest.hit, rsp.hit);
                    end
                    if (rsp.frame_out !== oldest.frame)
                    begin
                        errs++;
                        $display("%0t: frame_out mismatch, expected %h, got %h",
                                 $time, oldest.frame, rsp.frame_out);
                    end
                end
            end
            if (req.valid && req.ready)
                awaited_answers.push_back(
                    predict_translation(req.op, req.page_number, req.frame_number));
            mismatch_count       <= errs;
            translations_awaited <= awaited_answers.size();
        end
    end

endmodule

// ===== tb/sv/tb_fifo_fully_associative_tlb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_fifo_fully_associative_tlb
// Stimulus and verdict for the FIFO-replacement translation buffer.
// A short directed sequence covers the empty buffer, extreme pages and
// frames, update in place, remove with and without a match, insert into the
// pointer slot while another slot is free, and flush. A long random sequence
// over a small page pool then drives hits, updates, evictions and pointer
// wrap. Both channels idle at random, except during one calm stretch.
// ============================================================================
module tb_fifo_fully_associative_tlb;

    localparam int TLB_ENTRIES   = 16;
    localparam int PAGE_W        = 20;
    localparam int FRAME_W       = 16;
    localparam int RANDOM_ITEMS  = 1550;
    localparam int PHASE_ITEMS   = 260;
    localparam int POOL_SIZE     = 40;
    localparam int IDLE_PERCENT  = 16;
    localparam int SETTLE_CYCLES = 12;

    logic clk;
    logic rst_n;
    logic calm_stretch;
    int   mismatch_count;
    int   translations_awaited;

    fatlb_req_if #(.PAGE_WIDTH(PAGE_W), .FRAME_WIDTH(FRAME_W)) req_ch ();
    fatlb_rsp_if #(.FRAME_WIDTH(FRAME_W)) rsp_ch ();

    fifo_fully_associative_tlb #(
        .ENTRIES     (TLB_ENTRIES),
        .PAGE_WIDTH  (PAGE_W),
        .FRAME_WIDTH (FRAME_W)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    tlb_translation_monitor #(
        .ENTRIES     (TLB_ENTRIES),
        .PAGE_WIDTH  (PAGE_W),
        .FRAME_WIDTH (FRAME_W)
    ) u_monitor (
        .clk                  (clk),
        .rst_n                (rst_n),
        .req                  (req_ch),
        .rsp                  (rsp_ch),
        .mismatch_count       (mismatch_count),
        .translations_awaited (translations_awaited)
    );

    // 8 ns clock period.
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // The response side stalls on its own schedule, independent of the
    // request side, so stalls land on every step of the block's sequence.
    always @(posedge clk)
        rsp_ch.ready <= calm_stretch || ($urandom_range(0, 99) >= IDLE_PERCENT);

    // Presents one request transaction and holds it until the block takes
    // it. Random idle cycles come first; while idle the payload carries
    // noise, which the block must not act on.
    task automatic issue_request(
        fatlb_pkg::op_t     op,
        logic [PAGE_W-1:0]  page,
        logic [FRAME_W-1:0] frame
    );
        while (!calm_stretch && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            req_ch.valid        <= 1'b0;
            req_ch.op           <= fatlb_pkg::op_t'($urandom_range(0, 3));
            req_ch.page_number  <= PAGE_W'($urandom());
            req_ch.frame_number <= FRAME_W'($urandom());
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.op           <= op;
        req_ch.page_number  <= page;
        req_ch.frame_number <= frame;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Hand-picked sequence: each step depends on the buffer state left by
    // the ones before it.
    task automatic run_directed();
        issue_request(fatlb_pkg::OP_LOOKUP, 20'h00000, 16'h0000);  // lookup on an empty buffer
        issue_request(fatlb_pkg::OP_REMOVE, 20'h12345, 16'hFFFF);  // remove with nothing stored
        issue_request(fatlb_pkg::OP_INSERT, 20'h00000, 16'h0000);  // slot 0, lowest values
        issue_request(fatlb_pkg::OP_INSERT, 20'hFFFFF, 16'hFFFF);  // slot 1, highest values
        issue_request(fatlb_pkg::OP_LOOKUP, 20'h00000, 16'hFFFF);
        issue_request(fatlb_pkg::OP_LOOKUP, 20'hFFFFF, 16'h0000);
        issue_request(fatlb_pkg::OP_INSERT, 20'hFFFFF, 16'h1234);  // update in place
        issue_request(fatlb_pkg::OP_LOOKUP, 20'hFFFFF, 16'h0000);
        issue_request(fatlb_pkg::OP_REMOVE, 20'h00000, 16'h0000);  // frees slot 0
        issue_request(fatlb_pkg::OP_REMOVE, 20'h00000, 16'h0000);  // no match left
        issue_request(fatlb_pkg::OP_LOOKUP, 20'h00000, 16'h0000);
        // Slot 0 is free, but the new entry must still go to slot 2.
        issue_request(fatlb_pkg::OP_INSERT, 20'h55555, 16'hAAAA);
        issue_request(fatlb_pkg::OP_LOOKUP, 20'h55555, 16'hFFFF);  // frame ignored on lookup
        issue_request(fatlb_pkg::OP_LOOKUP, 20'hAAAAA, 16'h0000);
        issue_request(fatlb_pkg::OP_FLUSH,  20'hFFFFF, 16'hFFFF);
        issue_request(fatlb_pkg::OP_LOOKUP, 20'hFFFFF, 16'h0000);  // gone after flush
        issue_request(fatlb_pkg::OP_LOOKUP, 20'h55555, 16'h0000);
        issue_request(fatlb_pkg::OP_INSERT, 20'hAAAAA, 16'h5555);  // pointer back at slot 0
        issue_request(fatlb_pkg::OP_LOOKUP, 20'hAAAAA, 16'h0000);
        issue_request(fatlb_pkg::OP_REMOVE, 20'hAAAAA, 16'hFFFF);
        issue_request(fatlb_pkg::OP_LOOKUP, 20'hAAAAA, 16'h0000);
        issue_request(fatlb_pkg::OP_FLUSH,  20'h00000, 16'h0000);  // flush of an empty buffer
    endtask

    // Random traffic over a small pool of pages, so that lookups hit,
    // inserts update existing entries and the pointer wraps and evicts.
    // The pool span changes per phase to move between mostly hits and
    // heavy eviction; a few pages come from the whole range.
    task automatic run_random();
        logic [PAGE_W-1:0] page_pool [POOL_SIZE];
        int                pool_span [6];
        int                roll;
        int                phase;
        fatlb_pkg::op_t    op;
        logic [PAGE_W-1:0] page;
        pool_span = '{3, 15, 19, 39, 7, 31};
        foreach (page_pool[i])
            page_pool[i] = PAGE_W'($urandom());
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            phase = (n / PHASE_ITEMS) % 6;
            // One long stretch with no idling on either side.
            calm_stretch = (n >= 520 && n < 780);
            roll = $urandom_range(0, 99);
            if (roll < 42)
                op = fatlb_pkg::OP_LOOKUP;
            else if (roll < 78)
                op = fatlb_pkg::OP_INSERT;
            else if (roll < 97)
                op = fatlb_pkg::OP_REMOVE;
            else
                op = fatlb_pkg::OP_FLUSH;
            if ($urandom_range(0, 99) < 8)
                page = PAGE_W'($urandom());
            else
                page = page_pool[$urandom_range(0, pool_span[phase])];
            issue_request(op, page, FRAME_W'($urandom()));
        end
        calm_stretch = 1'b0;
    endtask

    initial
    begin
        calm_stretch = 1'b0;
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.op           <= fatlb_pkg::OP_LOOKUP;
        req_ch.page_number  <= '0;
        req_ch.frame_number <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random();
        req_ch.valid <= 1'b0;

        // Drain every outstanding response, then give the block time to
        // show any response it should not produce.
        do
            @(posedge clk);
        while (translations_awaited != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial
    begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
